// File: hdl/dcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared widths, calendar constants and the month start table for the
// day count to calendar date converter.
// ----------------------------------------------------------------------------
package dcd_pkg;

    // field widths
    localparam int DC_W      = 22;
    localparam int YEAR_W    = 14;
    localparam int MON_W     = 4;
    localparam int DOM_W     = 5;
    localparam int JUL_W     = 12;   // day of year, two's complement
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // calendar constants
    localparam int DAY_COUNT_MAX     = 3000000;
    localparam int EPOCH_SHIFT       = 55773;
    localparam int CENTURY_DAYS      = 36524;
    localparam int FOUR_CENTURY_DAYS = 146097;
    localparam int BASE_YEAR         = 1600;
    localparam int JUL_SHIFT         = 55757;
    localparam int YFRAC_MUL         = 1461;
    localparam int YFRAC_DIV         = 533630;

    // month estimate: (MON_SCALE*(jul-ly-MON_SHIFT) + MON_BIAS) / MON_STEP
    localparam int MON_SCALE  = 10000;
    localparam int MON_BIAS   = 911582;
    localparam int MON_STEP   = 305900;
    localparam int MON_SHIFT  = 59;
    localparam int EARLY_DAYS = 32;
    localparam int JAN_DAYS   = 31;

    typedef struct packed {
        logic ce;   // pipeline advance
        logic vld;  // beat present at the stage input
    } t_pipe_ctl;

    // Days before the first of month mon; leap day added from March on.
    function automatic logic [JUL_W-1:0] dcd_month_off(input logic [MON_W-1:0] mon,
                                                       input logic ly);
        logic [JUL_W-1:0] off;
        case (mon)
            4'd0:    off = '0 - JUL_W'(JAN_DAYS);
            4'd1:    off = '0;
            4'd2:    off = JUL_W'(JAN_DAYS);
            4'd3:    off = 12'd59;
            4'd4:    off = 12'd90;
            4'd5:    off = 12'd120;
            4'd6:    off = 12'd151;
            4'd7:    off = 12'd181;
            4'd8:    off = 12'd212;
            4'd9:    off = 12'd243;
            4'd10:   off = 12'd273;
            4'd11:   off = 12'd304;
            4'd12:   off = 12'd334;
            4'd13:   off = 12'd365;
            4'd14:   off = 12'd396;
            default: off = 12'd426;
        endcase
        if (mon >= 4'd3) begin
            off = off + JUL_W'(ly);
        end
        return off;
    endfunction

endpackage
`default_nettype wire

// File: hdl/dcd_year_to_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcd_year_to_date
// Back half of the converter: from year and day count to day of year,
// leap flag, month and day of month. Five stages, last one is the output.
// ----------------------------------------------------------------------------
module dcd_year_to_date (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire dcd_pkg::t_pipe_ctl          i_ctl,
    input  wire logic [dcd_pkg::YEAR_W-1:0]  i_yr,
    input  wire logic [dcd_pkg::DC_W-1:0]    i_dc,
    output logic                             o_vld,
    output logic [dcd_pkg::YEAR_W-1:0]       o_year,
    output logic [dcd_pkg::MON_W-1:0]        o_month,
    output logic [dcd_pkg::DOM_W-1:0]        o_dom
);
    import dcd_pkg::*;

    localparam int HUND_SHIFT = 20;
    localparam int HUND_RECIP = (1 << HUND_SHIFT) / 100 + 1;  // exact for 14-bit values
    localparam int HUND_Q_W   = 8;
    localparam int D365_W     = 23;
    localparam int SUM_W      = 26;
    localparam int NUM_W      = 27;
    localparam int NMON       = (1 << MON_W) - 1;

    logic [13:9] r_vld;

    // stage 9: year / 100 and days in whole years
    logic [YEAR_W-1:0]          r9_yr;
    logic [DC_W-1:0]            r9_dc;
    logic [HUND_Q_W-1:0]        r9_qa;
    logic [D365_W-1:0]          r9_d365;
    logic [2*YEAR_W-1:0]        n9_prod;
    // stage 10: day of year, leap flag
    logic [JUL_W-1:0]           r10_jul;
    logic                       r10_ly;
    logic                       n10_cen;
    logic [HUND_Q_W-1:0]        n10_qb;
    logic [SUM_W-1:0]           n10_sum;
    // stage 11: month numerator
    logic [JUL_W-1:0]           r11_jul;
    logic                       r11_ly;
    logic signed [NUM_W-1:0]    r11_num;
    logic [JUL_W-1:0]           n11_x;
    logic signed [NUM_W-1:0]    n11_xs;
    // stage 12: month
    logic [JUL_W-1:0]           r12_jul;
    logic                       r12_ly;
    logic [MON_W-1:0]           r12_mon;
    logic [MON_W-1:0]           n12_mon;
    // stage 13: output
    logic [YEAR_W-1:0]          r_yr10, r_yr11, r_yr12, r13_yr;
    logic [MON_W-1:0]           r13_mon;
    logic [DOM_W-1:0]           r13_dom;
    logic [JUL_W-1:0]           n13_day;

    always_comb begin
        n9_prod = (2*YEAR_W)'(i_yr) * (2*YEAR_W)'(HUND_RECIP);
    end

    always_comb begin
        n10_cen = (r9_yr == YEAR_W'(r9_qa * YEAR_W'(100)));
        n10_qb  = r9_qa - HUND_Q_W'(n10_cen);
        // (yr-1601)/4 and (yr-1601)/400 folded into constants
        n10_sum = SUM_W'(r9_dc) - SUM_W'(r9_d365) - SUM_W'((r9_yr - 14'd1) >> 2)
                + SUM_W'(n10_qb) - SUM_W'(n10_qb >> 2)
                + SUM_W'(JUL_SHIFT + BASE_YEAR / 4 + BASE_YEAR / 400);
    end

    always_comb begin
        n11_x  = r10_jul - JUL_W'(r10_ly) - JUL_W'(MON_SHIFT);
        n11_xs = {{(NUM_W-JUL_W){n11_x[JUL_W-1]}}, n11_x};
    end

    always_comb begin
        n12_mon = '0;
        if ($signed(r11_jul) < $signed(JUL_W'(EARLY_DAYS))) begin
            n12_mon = MON_W'(1);
        end else begin
            for (int m = 1; m <= NMON; m++) begin
                if (r11_num >= $signed(NUM_W'(MON_STEP * m))) begin
                    n12_mon = n12_mon + MON_W'(1);
                end
            end
        end
    end

    always_comb begin
        n13_day = r12_jul - dcd_month_off(r12_mon, r12_ly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.ce) begin
            r_vld <= {r_vld[12:9], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce) begin
            r9_yr   <= i_yr;
            r9_dc   <= i_dc;
            r9_qa   <= n9_prod[HUND_SHIFT +: HUND_Q_W];
            r9_d365 <= D365_W'(i_yr - YEAR_W'(BASE_YEAR)) * D365_W'(365);

            r_yr10  <= r9_yr;
            r10_jul <= n10_sum[JUL_W-1:0];
            r10_ly  <= n10_cen ? (r9_qa[1:0] == 2'd0) : (r9_yr[1:0] == 2'd0);

            r_yr11  <= r_yr10;
            r11_jul <= r10_jul;
            r11_ly  <= r10_ly;
            r11_num <= NUM_W'(n11_xs * $signed(NUM_W'(MON_SCALE)))
                     + $signed(NUM_W'(MON_BIAS));

            r_yr12  <= r_yr11;
            r12_jul <= r11_jul;
            r12_ly  <= r11_ly;
            r12_mon <= n12_mon;

            r13_yr  <= r_yr12;
            r13_mon <= r12_mon;
            r13_dom <= n13_day[DOM_W-1:0];
        end
    end

    assign o_vld   = r_vld[13];
    assign o_year  = r13_yr;
    assign o_month = r13_mon;
    assign o_dom   = r13_dom;

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ce && r_vld[9] |=> r_vld[10])
        else $error("beat lost between stages 9 and 10");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.ce |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_mon_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[12] && ($signed(r12_jul) >= $signed(JUL_W'(EARLY_DAYS))) |-> r12_mon >= 4'd2)
        else $error("month estimate below February after January");

endmodule
`default_nettype wire

// File: hdl/day_count_to_calendar_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// day_count_to_calendar_date
// Converts a day count from the 1752 epoch into Gregorian year, month, day.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one day count per beat in tdata[21:0];
//   counts above 3000000 are clamped to 3000000.
//   Master stream m_axis returns one date per beat: year, month, day.
//   Throughput: one beat per cycle while the receiver takes each beat.
//   Thirteen register stages (century split, year fraction, year/100,
//   day of year, month, day). The whole pipe moves on one enable: it
//   advances when the output register is empty or its beat is taken.
//   When the receiver stalls, every stage holds, s_axis tready drops
//   and no beat is lost or repeated; tready returns in the cycle the
//   output is taken.
//   Reset (i_rst_n low, synchronous) clears all stage valid bits; data
//   registers keep whatever they hold. There is no configuration.
// ----------------------------------------------------------------------------
module day_count_to_calendar_date (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [21:0] day_count, [23:22] zero
    input  wire logic [dcd_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [13:0] year, [17:14] month, [22:18] day_of_month, [23] zero
    output logic [dcd_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);
    import dcd_pkg::*;

    // reciprocal estimates, low by at most one, fixed by one compare
    localparam int CENT_SHIFT = DC_W;
    localparam int CENT_RECIP = (1 << CENT_SHIFT) / CENTURY_DAYS;
    localparam int CENT_Q_W   = 7;
    localparam int CREM_W     = 17;
    localparam int C2_W       = 16;
    localparam int P_W        = 26;
    localparam int YR_SHIFT   = P_W;
    localparam int YR_RECIP   = (1 << YR_SHIFT) / YFRAC_DIV;
    localparam int YQ_W       = 7;
    localparam int YREM_W     = 21;

    logic                      w_ce;
    t_pipe_ctl                 w_ctl;
    logic                      w_out_vld;
    logic [YEAR_W-1:0]         w_year;
    logic [MON_W-1:0]          w_mon;
    logic [DOM_W-1:0]          w_dom;

    logic [8:1]                r_vld;

    // stage 1: clamp, shift to century base
    logic [DC_W-1:0]           n1_dc, n1_c;
    logic [DC_W-1:0]           r1_dc, r1_x;
    logic                      r1_extra;
    // stage 2: century estimate
    logic [DC_W+CENT_Q_W-1:0]  n2_prod;
    logic [DC_W-1:0]           r2_dc, r2_x;
    logic                      r2_extra;
    logic [CENT_Q_W-1:0]       r2_q;
    // stage 3: century remainder
    logic [DC_W-1:0]           r3_dc;
    logic                      r3_extra;
    logic [CENT_Q_W-1:0]       r3_q;
    logic [CREM_W-1:0]         r3_r;
    // stage 4: corrected century, day within century
    logic                      n4_ge;
    logic [DC_W-1:0]           r4_dc;
    logic [CENT_Q_W-1:0]       r4_cent;
    logic [C2_W-1:0]           r4_c2;
    // stage 5: year fraction numerator, century year base
    logic [DC_W-1:0]           r5_dc;
    logic [P_W-1:0]            r5_p;
    logic [YEAR_W-1:0]         r5_yb;
    // stage 6: year-in-century estimate
    logic [P_W+YQ_W-1:0]       n6_prod;
    logic [DC_W-1:0]           r6_dc;
    logic [P_W-1:0]            r6_p;
    logic [YEAR_W-1:0]         r6_yb;
    logic [YQ_W-1:0]           r6_q;
    // stage 7: remainder
    logic [DC_W-1:0]           r7_dc;
    logic [YEAR_W-1:0]         r7_yb;
    logic [YQ_W-1:0]           r7_q;
    logic [YREM_W-1:0]         r7_r;
    // stage 8: year
    logic [DC_W-1:0]           r8_dc;
    logic [YEAR_W-1:0]         r8_yr;

    assign w_ce            = !w_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;

    always_comb begin
        n1_dc = (i_s_axis_tdata[DC_W-1:0] > DC_W'(DAY_COUNT_MAX)) ?
                DC_W'(DAY_COUNT_MAX) : i_s_axis_tdata[DC_W-1:0];
        n1_c  = n1_dc + DC_W'(EPOCH_SHIFT);
    end

    assign n2_prod = (DC_W+CENT_Q_W)'(r1_x) * (DC_W+CENT_Q_W)'(CENT_RECIP);
    assign n4_ge   = (r3_r >= CREM_W'(CENTURY_DAYS));
    assign n6_prod = (P_W+YQ_W)'(r5_p) * (P_W+YQ_W)'(YR_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[7:1], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_dc    <= n1_dc;
            r1_x     <= n1_c - DC_W'(1);
            r1_extra <= (n1_c > DC_W'(FOUR_CENTURY_DAYS));

            r2_dc    <= r1_dc;
            r2_x     <= r1_x;
            r2_extra <= r1_extra;
            r2_q     <= n2_prod[CENT_SHIFT +: CENT_Q_W];

            r3_dc    <= r2_dc;
            r3_extra <= r2_extra;
            r3_q     <= r2_q;
            r3_r     <= CREM_W'(r2_x - DC_W'(DC_W'(r2_q) * DC_W'(CENTURY_DAYS)));

            r4_dc    <= r3_dc;
            r4_cent  <= r3_q + CENT_Q_W'(n4_ge);
            r4_c2    <= C2_W'(r3_r - (n4_ge ? CREM_W'(CENTURY_DAYS) : CREM_W'(0))
                        + CREM_W'(1) - CREM_W'(r3_extra));

            r5_dc    <= r4_dc;
            r5_p     <= P_W'((P_W+1)'(r4_c2) * (P_W+1)'(YFRAC_MUL));
            r5_yb    <= YEAR_W'(r4_cent) * YEAR_W'(100) + YEAR_W'(BASE_YEAR);

            r6_dc    <= r5_dc;
            r6_p     <= r5_p;
            r6_yb    <= r5_yb;
            r6_q     <= n6_prod[YR_SHIFT +: YQ_W];

            r7_dc    <= r6_dc;
            r7_yb    <= r6_yb;
            r7_q     <= r6_q;
            r7_r     <= YREM_W'(r6_p - P_W'(P_W'(r6_q) * P_W'(YFRAC_DIV)));

            r8_dc    <= r7_dc;
            r8_yr    <= r7_yb + YEAR_W'(r7_q) + YEAR_W'(r7_r >= YREM_W'(YFRAC_DIV));
        end
    end

    // {ce, vld}
    assign w_ctl = {w_ce, r_vld[8]};

    dcd_year_to_date u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_yr    (r8_yr),
        .i_dc    (r8_dc),
        .o_vld   (w_out_vld),
        .o_year  (w_year),
        .o_month (w_mon),
        .o_dom   (w_dom)
    );

    assign o_m_axis_tvalid = w_out_vld;
    assign o_m_axis_tdata  = {1'b0, w_dom, w_mon, w_year};

    a_cent_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> r3_r < CREM_W'(2 * CENTURY_DAYS))
        else $error("century estimate off by more than one");

    a_cent_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> r4_c2 <= C2_W'(CENTURY_DAYS))
        else $error("day within century out of range");

    a_year_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> r7_r < YREM_W'(2 * YFRAC_DIV))
        else $error("year fraction estimate off by more than one");

    a_year_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[8] |-> (r8_yr >= 14'd1752) && (r8_yr <= 14'd9999))
        else $error("year out of range");

endmodule
`default_nettype wire

// File: dv/dcd_date_checker.sv
// ----------------------------------------------------------------------------
// dcd_date_checker
// Watches both stream channels of the day count converter. Each accepted
// day count is converted to a date here and queued. Each date beat on the
// output is checked against the oldest queued date.
// ----------------------------------------------------------------------------
module dcd_date_checker
    import dcd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // [21:0] day_count
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    // [13:0] year, [17:14] month, [22:18] day_of_month
    input  wire logic [M_TDATA_W-1:0] i_m_tdata,
    output int                        o_fail_count,
    output int                        o_pending
);

    // first day of month m >= 3 is (MON_STEP*m - MSTART_BIAS) / MON_SCALE
    localparam int MSTART_BIAS = 321582;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DOM_W-1:0]  dom;
    } cal_date_t;

    typedef struct packed {
        logic [DC_W-1:0] day_count;
        cal_date_t       date;
    } queued_date_t;

    queued_date_t date_q[$];
    int           fails = 0;

    function automatic cal_date_t predict_calendar_date(input logic [DC_W-1:0] day_count);
        longint    dc, c, cent, extra, yr, not_cent, ly, jul, mon, dom;
        cal_date_t d;
        dc = day_count;
        if (dc > DAY_COUNT_MAX) begin
            dc = DAY_COUNT_MAX;
        end
        // century split on the shifted count, one day dropped past 400 years
        c     = dc + EPOCH_SHIFT;
        cent  = (c - 1) / CENTURY_DAYS;
        extra = (c > FOUR_CENTURY_DAYS) ? 1 : 0;
        c     = c - cent * CENTURY_DAYS - extra;
        yr    = (YFRAC_MUL * c) / YFRAC_DIV + 100 * cent + BASE_YEAR;

        not_cent = ((yr % 100) > 0) ? 1 : 0;
        jul = dc - (yr - BASE_YEAR) * 365 - (yr - 1601) / 4 + JUL_SHIFT
            + (yr - 1) / 100 - (yr - 1601) / 400;
        ly  = 1 - not_cent * (((yr % 4) > 0) ? 1 : 0)
                - (1 - not_cent) * (((yr % 400) > 0) ? 1 : 0);

        if (jul < EARLY_DAYS) begin
            mon = 1;
        end else begin
            mon = (MON_SCALE * (jul - ly - MON_SHIFT) + MON_BIAS) / MON_STEP;
        end
        if (mon < 3) begin
            dom = jul - JAN_DAYS * (mon - 1);
        end else begin
            dom = jul - (MON_STEP * mon - MSTART_BIAS) / MON_SCALE - ly;
        end

        // drift cases (month 13, day 0) are kept, just truncated
        d.year  = yr[YEAR_W-1:0];
        d.month = mon[MON_W-1:0];
        d.dom   = dom[DOM_W-1:0];
        return d;
    endfunction

    always @(posedge i_clk) begin
        queued_date_t want;
        cal_date_t    got;
        if (i_rst_n) begin
            // output side first; a same-edge input beat cannot be its source
            if (i_m_tvalid && i_m_tready) begin
                got.year  = i_m_tdata[YEAR_W-1:0];
                got.month = i_m_tdata[YEAR_W+MON_W-1:YEAR_W];
                got.dom   = i_m_tdata[YEAR_W+MON_W+DOM_W-1:YEAR_W+MON_W];
                if (date_q.size() == 0) begin
                    $display("%0t: unexpected date beat: expected none, got %0d-%0d-%0d",
                             $time, got.year, got.month, got.dom);
                    fails++;
                end else begin
                    want = date_q.pop_front();
                    if (got.year !== want.date.year || got.month !== want.date.month ||
                        got.dom !== want.date.dom) begin
                        $display("%0t: day count %0d: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                                 $time, want.day_count,
                                 want.date.year, want.date.month, want.date.dom,
                                 got.year, got.month, got.dom);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want.day_count = i_s_tdata[DC_W-1:0];
                want.date      = predict_calendar_date(i_s_tdata[DC_W-1:0]);
                date_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= date_q.size();
    end

endmodule

// File: dv/tb_day_count_to_calendar_date.sv
// ----------------------------------------------------------------------------
// tb_day_count_to_calendar_date
// Drives day counts into the converter and takes dates out under random
// backpressure; the checker beside the block predicts and compares dates.
// ----------------------------------------------------------------------------
module tb_day_count_to_calendar_date;
    import dcd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 1000;    // plus the hold burst and directed set
    localparam int HOLD_BEATS   = 48;      // offered while the receiver holds off
    localparam int HOLD_CYCLES  = 120;     // long enough to back up all 13 stages
    localparam int SETTLE       = 30;      // > pipeline latency

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // [21:0] day_count, [23:22] zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // [13:0] year, [17:14] month, [22:18] dom
    int                   fail_count;
    int                   pending;

    // receiver backpressure state
    logic                 hold_req  = 1'b0;  // raised once by the stimulus
    logic                 hold_done = 1'b0;
    int                   hold_left = 0;
    int                   rx_phase  = 0;
    rx_mode_t             rx_mode   = RX_ALWAYS;
    int                   cycle_cnt = 0;

    // Directed day counts: epoch, first days of 1753, the 1800 century
    // start (no leap day), the 400-year boundary at 2000 with its leap day,
    // the saturation point and counts above it, and some bit patterns.
    int directed_days [0:24] = '{
        0, 1, 108, 109, 139, 140,
        17274, 17275, 17333, 17334,
        90323, 90324, 90325, 90383, 90384, 90689, 90690,
        2999999, 3000000, 3000001, 4194303,
        2097152, 1398101, 2796202, 1048575
    };

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    day_count_to_calendar_date dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    dcd_date_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: one forced long hold-off, rare random hold-offs, otherwise a
    // pattern picked anew whenever rx_phase wraps (free flow, coin toss,
    // mostly stalled, alternating).
    always @(posedge clk) begin
        rx_phase <= (rx_phase + 1) % 64;
        if (rx_phase == 63) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if ($urandom_range(0, 499) == 0) begin
            m_tready  <= 1'b0;
            hold_left <= $urandom_range(20, 60);
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    m_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                RX_SPARSE: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= ~m_tready;
                end
            endcase
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one day count and hold it until the beat is taken. Valid stays
    // high between calls, so back-to-back beats follow without a gap.
    task automatic send_day_count(input logic [DC_W-1:0] dc);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-DC_W){1'b0}}, dc};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic idle_cycles(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop sending and wait for every queued date to come out. The first
    // edge lets the checker count a beat taken on the edge just passed.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Mix: plain range, saturating counts, and counts around century and
    // 400-year boundaries, where year ends and drift cases cluster.
    function automatic logic [DC_W-1:0] pick_day_count();
        int     sel;
        int     offs;
        longint v;
        sel  = $urandom_range(0, 99);
        offs = int'($urandom_range(0, 800)) - 400;
        if (sel < 60) begin
            v = $urandom_range(0, DAY_COUNT_MAX);
        end else if (sel < 70) begin
            v = $urandom_range(DAY_COUNT_MAX + 1, (1 << DC_W) - 1);
        end else if (sel < 90) begin
            v = longint'($urandom_range(2, 83)) * CENTURY_DAYS - EPOCH_SHIFT + offs;
        end else begin
            v = longint'($urandom_range(1, 20)) * FOUR_CENTURY_DAYS - EPOCH_SHIFT + offs;
        end
        return v[DC_W-1:0];
    endfunction

    initial begin
        int sent;
        int burst;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed set, then a full drain with the sender paused
        foreach (directed_days[i]) begin
            send_day_count(DC_W'(directed_days[i]));
        end
        wait_drained();

        // receiver holds off while beats keep coming: pipe fills, tready drops
        hold_req <= 1'b1;
        repeat (HOLD_BEATS) send_day_count(pick_day_count());
        wait_drained();

        // random bursts with random gaps, now and then a full drain
        while (sent < RANDOM_BEATS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                send_day_count(pick_day_count());
                sent++;
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end else if ($urandom_range(0, 3) != 0) begin
                idle_cycles($urandom_range(1, 8));
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
